[design/rlh_pkg.sv]
// ----------------------------------------------------------------------------
// rlh_pkg
// Shared types and default sizes for the running hyperperiod block.
// ----------------------------------------------------------------------------
package rlh_pkg;

    localparam int PERIOD_BITS_DEF = 32;
    localparam int LCM_BITS_DEF    = 64;

    typedef struct packed {
        logic start;
        logic take;
    } rlh_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rlh_sts_t;

endpackage
// ----------------------------------------------------------------------------

[design/rlh_addsub.sv]
// ----------------------------------------------------------------------------
// rlh_addsub
// Shared adder and subtractor used by the GCD, divide and multiply steps of the core.
// ----------------------------------------------------------------------------
module rlh_addsub #(
    parameter int WIDTH = rlh_pkg::LCM_BITS_DEF + 2
) (
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic             sub,
    output logic [WIDTH-1:0] sum,
    output logic             carry
);

    logic [WIDTH:0] full;

    assign full  = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + {{WIDTH{1'b0}}, sub};
    assign sum   = full[WIDTH-1:0];
    assign carry = full[WIDTH];

endmodule
// ----------------------------------------------------------------------------

[design/rlh_core.sv]
// ----------------------------------------------------------------------------
// rlh_core
// Sequencer and datapath: binary GCD, restoring divide and shift-add
// multiply, all through one shared adder.
// ----------------------------------------------------------------------------
module rlh_core #(
    parameter int PERIOD_BITS = rlh_pkg::PERIOD_BITS_DEF,
    parameter int LCM_BITS    = rlh_pkg::LCM_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rlh_pkg::rlh_ctl_t      ctl,
    input  logic [PERIOD_BITS-1:0] period,
    input  logic                   first_of_set,
    output rlh_pkg::rlh_sts_t      sts,
    output logic [LCM_BITS-1:0]    lcm,
    output logic                   ovf
);

    localparam int GW = (LCM_BITS > PERIOD_BITS) ? LCM_BITS : PERIOD_BITS;
    localparam int AW = GW + 2;
    localparam int CW = $clog2(GW + 1);

    localparam logic [LCM_BITS-1:0] LCM_MAX = '1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TWOS = 3'd1;
    localparam logic [2:0] ST_GCD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [LCM_BITS-1:0]    lcm_reg, lcm_next;
    logic                   ovf_reg, ovf_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [GW-1:0]          x_reg, x_next;
    logic [GW-1:0]          y_reg, y_next;
    logic [GW-1:0]          rem_reg, rem_next;
    logic [LCM_BITS-1:0]    num_reg, num_next;
    logic [LCM_BITS-1:0]    acc_reg, acc_next;
    logic                   mov_reg, mov_next;
    logic [PERIOD_BITS-1:0] p_reg, p_next;

    logic [AW-1:0]          add_a;
    logic [AW-1:0]          add_b;
    logic                   add_sub;
    logic [AW-1:0]          add_sum;
    logic                   add_carry;

    rlh_addsub #(
        .WIDTH (AW)
    ) u_addsub (
        .op_a  (add_a),
        .op_b  (add_b),
        .sub   (add_sub),
        .sum   (add_sum),
        .carry (add_carry)
    );

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            ST_GCD:
            begin
                add_a   = {2'b00, x_reg};
                add_b   = {2'b00, y_reg};
                add_sub = 1'b1;
            end
            ST_DIV:
            begin
                add_a   = {1'b0, rem_reg, num_reg[LCM_BITS-1]};
                add_b   = {2'b00, x_reg};
                add_sub = 1'b1;
            end
            ST_MUL:
            begin
                add_a   = {{(AW-LCM_BITS-1){1'b0}}, acc_reg, 1'b0};
                add_b   = p_reg[PERIOD_BITS-1] ? {{(AW-LCM_BITS){1'b0}}, num_reg} : '0;
                add_sub = 1'b0;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        logic [GW-1:0] p_ext;
        logic [GW-1:0] a_ext;

        p_ext      = GW'(period);
        a_ext      = GW'(lcm_reg);
        state_next = state_reg;
        lcm_next   = lcm_reg;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        acc_next   = acc_reg;
        mov_next   = mov_reg;
        p_next     = p_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    if (first_of_set)
                    begin
                        if ((p_ext >> LCM_BITS) != '0)
                        begin
                            lcm_next = LCM_MAX;
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            lcm_next = LCM_BITS'(p_ext);
                            ovf_next = 1'b0;
                        end
                        state_next = ST_DONE;
                    end
                    else if (lcm_reg == '0 || period == '0)
                    begin
                        lcm_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        x_next     = a_ext;
                        y_next     = p_ext;
                        num_next   = lcm_reg;
                        p_next     = period;
                        state_next = ST_TWOS;
                    end
                end
            end
            ST_TWOS:
            begin
                // Shared powers of two leave both operands and the dividend.
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next   = x_reg >> 1;
                    y_next   = y_reg >> 1;
                    num_next = num_reg >> 1;
                end
                else
                begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (!add_carry)
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
                else if (add_sum == '0)
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    x_next = add_sum[GW:1];
                end
            end
            ST_DIV:
            begin
                if (add_carry)
                begin
                    rem_next = add_sum[GW-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[GW-2:0], num_reg[LCM_BITS-1]};
                end
                num_next = {num_reg[LCM_BITS-2:0], add_carry};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(LCM_BITS - 1))
                begin
                    cnt_next   = '0;
                    acc_next   = '0;
                    mov_next   = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_next = add_sum[LCM_BITS-1:0];
                mov_next = mov_reg || (add_sum[AW-1:LCM_BITS] != '0);
                p_next   = p_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(PERIOD_BITS - 1))
                begin
                    if (mov_next)
                    begin
                        lcm_next = LCM_MAX;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        lcm_next = acc_next;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (ctl.take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lcm_reg   <= '0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lcm_reg   <= lcm_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        acc_reg <= acc_next;
        mov_reg <= mov_next;
        p_reg   <= p_next;
    end

    assign sts.busy = (state_reg != ST_IDLE);
    assign sts.done = (state_reg == ST_DONE);
    assign lcm      = lcm_reg;
    assign ovf      = ovf_reg;

endmodule
// ----------------------------------------------------------------------------

[design/running_lcm_hyperperiod.sv]
// ----------------------------------------------------------------------------
// running_lcm_hyperperiod
// Running least common multiple of a stream of task periods.
// ----------------------------------------------------------------------------
// The block takes one item at a time and holds task_stall high until that
// item's result has been taken into the output register. An item that starts
// a set, or that meets a zero operand, goes straight to the done state. Any
// other item runs a binary GCD, a restoring divide of LCM_BITS steps and a
// shift-add multiply of PERIOD_BITS steps, all on one shared adder; the GCD
// takes one step per halving or subtraction and one more per operand swap.
// A finished result sits in an output register, so a new item is taken
// while the last result waits.
// ----------------------------------------------------------------------------
module running_lcm_hyperperiod #(
    parameter int PERIOD_BITS = rlh_pkg::PERIOD_BITS_DEF,
    parameter int LCM_BITS    = rlh_pkg::LCM_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   task_valid,
    output logic                   task_stall,
    input  logic [PERIOD_BITS-1:0] period,
    input  logic                   first_of_set,
    output logic                   lcm_valid,
    input  logic                   lcm_stall,
    output logic [LCM_BITS-1:0]    hyperperiod,
    output logic                   overflowed
);

    rlh_pkg::rlh_ctl_t     ctl;
    rlh_pkg::rlh_sts_t     sts;
    logic [LCM_BITS-1:0]   core_lcm;
    logic                  core_ovf;

    logic                  out_valid_reg, out_valid_next;
    logic [LCM_BITS-1:0]   hyper_reg;
    logic                  ovf_out_reg;

    rlh_core #(
        .PERIOD_BITS (PERIOD_BITS),
        .LCM_BITS    (LCM_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .period       (period),
        .first_of_set (first_of_set),
        .sts          (sts),
        .lcm          (core_lcm),
        .ovf          (core_ovf)
    );

    assign ctl.start = task_valid && !sts.busy;
    assign ctl.take  = sts.done && (!out_valid_reg || !lcm_stall);

    assign out_valid_next = ctl.take || (out_valid_reg && lcm_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            hyper_reg   <= core_lcm;
            ovf_out_reg <= core_ovf;
        end
    end

    assign task_stall  = sts.busy;
    assign lcm_valid   = out_valid_reg;
    assign hyperperiod = hyper_reg;
    assign overflowed  = ovf_out_reg;

endmodule
// ----------------------------------------------------------------------------
